/* hw/rtl/ocp_pkg.sv */
// Shared constants, angle table and helpers for the orbit camera block.
`timescale 1ns / 1ps
`default_nettype none
package ocp_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 16;
  localparam int ITER_W             = 5;

  localparam int DELTA_W = 11;
  localparam int SENS_W  = 12;
  localparam int DIST_W  = 16;
  localparam int COORD_W = 24;
  localparam int YAW_W   = 17;
  localparam int PITCH_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SENS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TZ   = 3'd4;

  localparam logic [SENS_W-1:0] SENS_RESET = 12'd77;
  localparam logic [DIST_W-1:0] DIST_RESET = 16'd1792;

  localparam int YAW_RESET    = -23040;
  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int PITCH_MIN    = -22784;
  localparam int WRAP_BIAS    = 5898240;
  localparam int POS_MAX      = 8388607;
  localparam int POS_MIN      = -8388608;
  localparam longint GAIN_Q30 = 64'd652032874;

  function automatic logic [31:0] atan_deg(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489089;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic longint gain_start(input int frac);
    return (GAIN_Q30 + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ocp_if.sv */
// Handshake channel interfaces for pointer items and camera items.
`timescale 1ns / 1ps
`default_nettype none
interface ocp_in_if;
  logic valid;
  logic ready;
  logic signed [ocp_pkg::DELTA_W-1:0] delta_x;
  logic signed [ocp_pkg::DELTA_W-1:0] delta_y;
  modport source (output valid, delta_x, delta_y, input ready);
  modport sink   (input valid, delta_x, delta_y, output ready);
endinterface

interface ocp_out_if;
  logic valid;
  logic ready;
  logic signed [ocp_pkg::YAW_W-1:0]   yaw_angle;
  logic signed [ocp_pkg::PITCH_W-1:0] pitch_angle;
  logic signed [ocp_pkg::COORD_W-1:0] pos_x;
  logic signed [ocp_pkg::COORD_W-1:0] pos_y;
  logic signed [ocp_pkg::COORD_W-1:0] pos_z;
  modport source (output valid, yaw_angle, pitch_angle, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ocp_serial_mul.sv */
// Shift-add signed multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ocp_serial_mul #(
  parameter int W = 19
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [W-1:0]     a,
  input  wire logic signed [W-1:0]     b,
  output logic                         done,
  output logic signed [2*W-1:0]        prod
);
  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic signed [2*W-1:0] acc_r, acc_nxt;
  logic signed [2*W-1:0] mc_r, mc_nxt;
  logic [W-1:0]          mp_r, mp_nxt;
  logic                  last;

  assign last = (cnt_r == CW'(W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      mc_nxt   = (2*W)'(a);
      mp_nxt   = b;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = last ? acc_r - mc_r : acc_r + mc_r;
      end
      mc_nxt  = mc_r <<< 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

/* hw/rtl/ocp_cordic.sv */
// Rotation-mode CORDIC for sine and cosine of a Q.8 degree angle.
`timescale 1ns / 1ps
`default_nettype none
module ocp_cordic #(
  parameter int F = ocp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [ocp_pkg::YAW_W-1:0] angle,
  output logic                               done,
  output logic signed [F+2:0]                sin_o,
  output logic signed [F+2:0]                cos_o
);
  import ocp_pkg::*;

  localparam int TW = F + 3;
  localparam int ZW = 33;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 neg_r, neg_nxt;
  logic [ITER_W-1:0]    cnt_r, cnt_nxt;
  logic signed [TW-1:0] x_r, x_nxt;
  logic signed [TW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [YAW_W-1:0] ang;
  logic signed [TW-1:0] xs, ys;
  logic signed [ZW-1:0] at;

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = $signed(ZW'(atan_deg(cnt_r)));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    ang      = angle;
    if (start) begin
      neg_nxt = 1'b0;
      if (angle > YAW_W'(QUARTER_TURN)) begin
        ang     = angle - YAW_W'(HALF_TURN);
        neg_nxt = 1'b1;
      end else if (angle < -YAW_W'(QUARTER_TURN)) begin
        ang     = angle + YAW_W'(HALF_TURN);
        neg_nxt = 1'b1;
      end
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = TW'(gain_start(F));
      y_nxt    = '0;
      z_nxt    = ZW'(ang) <<< 16;
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + ITER_W'(1);
      if (cnt_r == ITER_W'(F - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
  end

  assign done  = done_r;
  assign sin_o = neg_r ? -y_r : y_r;
  assign cos_o = neg_r ? -x_r : x_r;
endmodule
`default_nettype wire

/* hw/rtl/orbit_camera_position.sv */
// Top level: orbit camera angle update, direction and position sequencer.
//
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid / ready      | delta_x, delta_y
//  out_ch  | out | valid / ready      | yaw_angle, pitch_angle, pos_x, pos_y, pos_z
//  cfg     | in  | cfg_we (no stall)  | cfg_index, cfg_wdata
//
// Each item passes a yaw reduction, two CORDIC runs of F iterations (yaw, then
// pitch; F = TRIG_FRAC_BITS) and five products on the bit-serial multiplier,
// which is M = max(F+3, 17) bits wide.
// in_ch.ready is high only while the sequencer is idle; a finished item waits
// in the output register, and the next item is taken meanwhile.
// Synchronous reset sets yaw to -90 degrees, pitch to 0 and the registers to
// their defaults.
`timescale 1ns / 1ps
`default_nettype none
module orbit_camera_position #(
  parameter int TRIG_FRAC_BITS = ocp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ocp_in_if.sink                              in_ch,
  ocp_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ocp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ocp_pkg::COORD_W-1:0]    cfg_wdata
);
  import ocp_pkg::*;

  localparam int F  = TRIG_FRAC_BITS;
  localparam int TW = F + 3;
  localparam int MW = (TW > 17) ? TW : 17;
  localparam int PW = 2 * MW;
  localparam int RW = 25;
  localparam int SW = 26;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RED     = 4'd1;
  localparam logic [3:0] S_CY_GO   = 4'd2;
  localparam logic [3:0] S_CY_WAIT = 4'd3;
  localparam logic [3:0] S_CP_GO   = 4'd4;
  localparam logic [3:0] S_CP_WAIT = 4'd5;
  localparam logic [3:0] S_MUL_GO  = 4'd6;
  localparam logic [3:0] S_MUL_WT  = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0] state_r;
  logic [SENS_W-1:0] sens_r;
  logic [DIST_W-1:0] dist_r;
  logic signed [COORD_W-1:0] tx_r, ty_r, tz_r;
  logic signed [YAW_W-1:0]   yaw_acc_r;
  logic signed [PITCH_W-1:0] pitch_acc_r;
  logic [RW-1:0] red_r;
  logic [2:0]    k_r;
  logic [2:0]    step_r;
  logic signed [TW-1:0] sy_r, cy_r, sp_r, cp_r, ux_r, uz_r;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic out_valid_r;
  logic signed [YAW_W-1:0]   yaw_o_r;
  logic signed [PITCH_W-1:0] pitch_o_r;
  logic signed [COORD_W-1:0] pxo_r, pyo_r, pzo_r;

  logic accept;
  logic signed [23:0] dx_prod, dy_prod;
  logic signed [RW-1:0] yaw_sum, pit_sum;
  logic [RW-1:0] turn_k;

  logic cor_start, cor_done;
  logic signed [YAW_W-1:0] cor_ang;
  logic signed [TW-1:0] cor_sin, cor_cos;

  logic mul_start, mul_done;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p, mul_rs;
  logic signed [TW-1:0] rs_trig;
  logic signed [SW-1:0] rs_pos, pos_diff;
  logic signed [COORD_W-1:0] pos_sat, tgt;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);

  assign dx_prod = in_ch.delta_x * $signed({1'b0, sens_r});
  assign dy_prod = in_ch.delta_y * $signed({1'b0, sens_r});
  assign yaw_sum = RW'(yaw_acc_r) + RW'(dx_prod) + RW'(HALF_TURN);
  assign pit_sum = RW'(pitch_acc_r) + RW'(dy_prod);
  assign turn_k  = RW'(FULL_TURN) << k_r;

  assign cor_start = (state_r == S_CY_GO) || (state_r == S_CP_GO);
  assign cor_ang   = (state_r == S_CY_GO) ? YAW_W'(red_r) - YAW_W'(HALF_TURN) :
                                            YAW_W'(pitch_acc_r);

  ocp_cordic #(.F(F)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_ang),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  always_comb begin
    mul_a = MW'(cp_r);
    mul_b = MW'(cy_r);
    tgt   = tx_r;
    case (step_r)
      3'd0: begin
        mul_a = MW'(cp_r);
        mul_b = MW'(cy_r);
      end
      3'd1: begin
        mul_a = MW'(cp_r);
        mul_b = MW'(sy_r);
      end
      3'd2: begin
        mul_a = MW'(ux_r);
        mul_b = MW'($signed({1'b0, dist_r}));
        tgt   = tx_r;
      end
      3'd3: begin
        mul_a = MW'(sp_r);
        mul_b = MW'($signed({1'b0, dist_r}));
        tgt   = ty_r;
      end
      3'd4: begin
        mul_a = MW'(uz_r);
        mul_b = MW'($signed({1'b0, dist_r}));
        tgt   = tz_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state_r == S_MUL_GO);

  ocp_serial_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  assign mul_rs   = (mul_p + (PW'(1) <<< (F - 1))) >>> F;
  assign rs_trig  = TW'(mul_rs);
  assign rs_pos   = SW'(mul_rs);
  assign pos_diff = SW'(tgt) - rs_pos;
  assign pos_sat  = (pos_diff > SW'(POS_MAX)) ? COORD_W'(POS_MAX) :
                    (pos_diff < SW'(POS_MIN)) ? COORD_W'(POS_MIN) : COORD_W'(pos_diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= SENS_RESET;
      dist_r <= DIST_RESET;
      tx_r   <= '0;
      ty_r   <= '0;
      tz_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS: sens_r <= cfg_wdata[SENS_W-1:0];
        REG_DIST: dist_r <= cfg_wdata[DIST_W-1:0];
        REG_TX:   tx_r   <= cfg_wdata;
        REG_TY:   ty_r   <= cfg_wdata;
        REG_TZ:   tz_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      yaw_acc_r   <= YAW_W'(YAW_RESET);
      pitch_acc_r <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      step_r      <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            red_r <= yaw_sum[RW-1] ? yaw_sum + RW'(WRAP_BIAS) : yaw_sum;
            if (pit_sum > 0) begin
              pitch_acc_r <= '0;
            end else if (pit_sum < RW'(PITCH_MIN)) begin
              pitch_acc_r <= PITCH_W'(PITCH_MIN);
            end else begin
              pitch_acc_r <= PITCH_W'(pit_sum);
            end
            k_r     <= 3'd7;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (red_r >= turn_k) begin
            red_r <= red_r - turn_k;
          end
          if (k_r == 3'd0) begin
            state_r <= S_CY_GO;
          end
          k_r <= k_r - 3'd1;
        end
        S_CY_GO: begin
          yaw_acc_r <= YAW_W'(red_r) - YAW_W'(HALF_TURN);
          state_r   <= S_CY_WAIT;
        end
        S_CY_WAIT: begin
          if (cor_done) begin
            sy_r    <= cor_sin;
            cy_r    <= cor_cos;
            state_r <= S_CP_GO;
          end
        end
        S_CP_GO: state_r <= S_CP_WAIT;
        S_CP_WAIT: begin
          if (cor_done) begin
            sp_r    <= cor_sin;
            cp_r    <= cor_cos;
            step_r  <= '0;
            state_r <= S_MUL_GO;
          end
        end
        S_MUL_GO: state_r <= S_MUL_WT;
        S_MUL_WT: begin
          if (mul_done) begin
            case (step_r)
              3'd0: ux_r <= rs_trig;
              3'd1: uz_r <= rs_trig;
              3'd2: px_r <= pos_sat;
              3'd3: py_r <= pos_sat;
              default: pz_r <= pos_sat;
            endcase
            step_r  <= step_r + 3'd1;
            state_r <= (step_r == 3'd4) ? S_OUT : S_MUL_GO;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            yaw_o_r     <= yaw_acc_r;
            pitch_o_r   <= pitch_acc_r;
            pxo_r       <= px_r;
            pyo_r       <= py_r;
            pzo_r       <= pz_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.yaw_angle   = yaw_o_r;
  assign out_ch.pitch_angle = pitch_o_r;
  assign out_ch.pos_x       = pxo_r;
  assign out_ch.pos_y       = pyo_r;
  assign out_ch.pos_z       = pzo_r;

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_acc_r <= 0) && (pitch_acc_r >= PITCH_W'(PITCH_MIN)))
    else $error("pitch out of range");

  a_accept_red: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RED))
    else $error("accepted item did not start reduction");

  a_wrap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CY_GO) |-> (red_r < RW'(FULL_TURN)))
    else $error("yaw reduction incomplete");
endmodule
`default_nettype wire

/* test/tb_orbit_camera_position.sv */
// Testbench for orbit_camera_position: directed and random pointer items checked against a predictor.
`timescale 1ns / 1ps
module tb_orbit_camera_position;
  import ocp_pkg::*;

  localparam int F = TRIG_FRAC_BITS_DEF;
  localparam int SETTLE = 160;

  typedef struct packed {
    logic signed [YAW_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } camera_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_wdata;

  ocp_in_if  in_ch();
  ocp_out_if out_ch();

  orbit_camera_position u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  longint sens_q, dist_q, tgt_x, tgt_y, tgt_z, yaw_q, pitch_q;
  camera_t cam_expected[$];
  int mismatches;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever begin
      #2 clk = 1'b1;
      #2 clk = 1'b0;
    end
  end

  initial begin
    #20ms;
    $display("[orbit_camera_position] ERROR");
    $finish;
  end

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  task automatic cordic_sincos(input longint ang, output longint s, output longint c);
    bit neg;
    longint x, y, z, nx;
    neg = 1'b0;
    if (ang > QUARTER_TURN) begin
      ang -= HALF_TURN;
      neg = 1'b1;
    end else if (ang < -QUARTER_TURN) begin
      ang += HALF_TURN;
      neg = 1'b1;
    end
    x = (652032874 + (64'sd1 <<< (29 - F))) >>> (30 - F);
    y = 0;
    z = ang * 65536;
    for (int i = 0; i < F && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_deg(i[ITER_W-1:0]));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_deg(i[ITER_W-1:0]));
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic predict_camera(input logic signed [DELTA_W-1:0] dx,
                                input logic signed [DELTA_W-1:0] dy);
    longint t, sy, cy, sp, cp, ux, uz;
    camera_t r;
    t = yaw_q + longint'(dx) * sens_q + HALF_TURN;
    t = t % FULL_TURN;
    if (t < 0) t += FULL_TURN;
    yaw_q = t - HALF_TURN;
    t = pitch_q + longint'(dy) * sens_q;
    if (t > 0) t = 0;
    if (t < PITCH_MIN) t = PITCH_MIN;
    pitch_q = t;
    cordic_sincos(yaw_q, sy, cy);
    cordic_sincos(pitch_q, sp, cp);
    ux = round_q(cp * cy, F);
    uz = round_q(cp * sy, F);
    r.yaw   = yaw_q[YAW_W-1:0];
    r.pitch = pitch_q[PITCH_W-1:0];
    r.px = COORD_W'(sat_coord(tgt_x - round_q(ux * dist_q, F)));
    r.py = COORD_W'(sat_coord(tgt_y - round_q(sp * dist_q, F)));
    r.pz = COORD_W'(sat_coord(tgt_z - round_q(uz * dist_q, F)));
    cam_expected.push_back(r);
  endtask

  // result side: random stalls, compare each item
  always @(posedge clk) begin
    camera_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.yaw_angle, out_ch.pitch_angle, out_ch.pos_x, out_ch.pos_y,
                out_ch.pos_z};
        if (cam_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected camera item %p", got);
        end else begin
          want = cam_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, got);
          end
        end
        stall_left <= $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_move(input logic signed [DELTA_W-1:0] dx,
                           input logic signed [DELTA_W-1:0] dy);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.delta_x <= dx;
    in_ch.delta_y <= dy;
    do @(posedge clk); while (!in_ch.ready);
    predict_camera(dx, dy);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (cam_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SENS: sens_q = val[SENS_W-1:0];
      REG_DIST: dist_q = val[DIST_W-1:0];
      REG_TX:   tgt_x = longint'($signed(val));
      REG_TY:   tgt_y = longint'($signed(val));
      REG_TZ:   tgt_z = longint'($signed(val));
      default: ;
    endcase
  endtask

  function automatic logic [DELTA_W-1:0] rand_delta;
    if ($urandom_range(0, 9) < 7) return DELTA_W'($signed($urandom_range(0, 40)) - 20);
    return DELTA_W'($urandom);
  endfunction

  task automatic test_reset_defaults;
    send_move(11'sd0, 11'sd0);
    send_move(11'sd1023, 11'sd1023);
    send_move(-11'sd1024, -11'sd1024);
    send_move(11'sd200, -11'sd100);
    send_move(-11'sd300, 11'sd5);
  endtask

  task automatic test_extremes;
    write_reg(REG_SENS, 24'hFFFFFF);
    send_move(11'sd1023, 11'sd0);
    send_move(-11'sd1024, -11'sd1024);
    send_move(11'sd1, 11'sd1023);
    send_move(-11'sd1024, 11'sd1);
    write_reg(REG_SENS, 24'd0);
    send_move(11'sd1023, -11'sd1024);
    send_move(-11'sd1024, 11'sd1023);
    write_reg(REG_DIST, 24'h00FFFF);
    write_reg(REG_TX, 24'h7FFFFF);
    write_reg(REG_TY, 24'h800000);
    write_reg(REG_TZ, 24'h7FFFFF);
    write_reg(REG_SENS, 24'd256);
    send_move(11'sd90, -11'sd45);
    send_move(11'sd90, -11'sd45);
    send_move(-11'sd180, -11'sd100);
    write_reg(3'd5, 24'h123456);
    write_reg(3'd7, 24'hFFFFFF);
    send_move(11'sd3, -11'sd3);
    write_reg(REG_TX, 24'h800000);
    write_reg(REG_TY, 24'h7FFFFF);
    write_reg(REG_TZ, 24'h800000);
    send_move(11'sd45, 11'sd30);
    send_move(-11'sd20, -11'sd89);
    write_reg(REG_DIST, 24'd0);
    send_move(11'sd7, 11'sd7);
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: write_reg(REG_SENS, 24'd77);
        1: write_reg(REG_SENS, 24'd0);
        2: write_reg(REG_SENS, 24'hFFF);
        default: write_reg(REG_SENS, COORD_W'($urandom));
      endcase
      case (phase % 3)
        0: write_reg(REG_DIST, 24'd1792);
        1: write_reg(REG_DIST, 24'hFFFF);
        default: write_reg(REG_DIST, COORD_W'($urandom));
      endcase
      write_reg(REG_TX, (phase == 5) ? 24'h7FFFFF :
                        ((phase < 2) ? 24'd0 : COORD_W'($urandom)));
      write_reg(REG_TY, (phase == 6) ? 24'h800000 :
                        ((phase < 2) ? 24'd0 : COORD_W'($urandom)));
      write_reg(REG_TZ, COORD_W'($urandom));
      repeat (106) send_move(rand_delta(), rand_delta());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.delta_x = '0;
    in_ch.delta_y = '0;
    mismatches = 0;
    sens_q = 77;
    dist_q = 1792;
    tgt_x = 0;
    tgt_y = 0;
    tgt_z = 0;
    yaw_q = YAW_RESET;
    pitch_q = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_random();
    drain();
    if (mismatches == 0 && cam_expected.size() == 0) begin
      $display("[orbit_camera_position] OK");
    end else begin
      $display("[orbit_camera_position] ERROR");
    end
    $finish;
  end
endmodule
